### src/gng_pkg.sv
// shared types, constants and tables for the gaussian noise generator
`timescale 1ns / 1ps
package gng_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W             = 22;
  localparam int SIGMA_W              = 18;
  localparam int SEED_W               = 64;

  localparam logic [63:0] SEED_RESET  = 64'h00C0FFEE12345678;
  localparam logic [52:0] U1_FLOOR    = 53'd9008;
  localparam logic [31:0] LN2_Q32     = 32'hB17217F8;
  localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;

  localparam int LOG_STEPS  = 24;
  localparam int SQRT_STEPS = 20;
  localparam int TERMS      = 6;

  // sequencer codes, one per datapath operation
  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_ADV1  = 5'd1;
  localparam logic [4:0] OP_ADV2  = 5'd2;
  localparam logic [4:0] OP_NORM  = 5'd3;
  localparam logic [4:0] OP_LOG   = 5'd4;
  localparam logic [4:0] OP_LQ    = 5'd5;
  localparam logic [4:0] OP_LN    = 5'd6;
  localparam logic [4:0] OP_SQRT  = 5'd7;
  localparam logic [4:0] OP_ANGLE = 5'd8;
  localparam logic [4:0] OP_X2    = 5'd9;
  localparam logic [4:0] OP_TMUL  = 5'd10;
  localparam logic [4:0] OP_TDIV  = 5'd11;
  localparam logic [4:0] OP_TACC  = 5'd12;
  localparam logic [4:0] OP_PMUL0 = 5'd13;
  localparam logic [4:0] OP_PMUL1 = 5'd14;
  localparam logic [4:0] OP_PMUL2 = 5'd15;
  localparam logic [4:0] OP_ROUND = 5'd16;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] term;
    logic       capture;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_busy;
  } sts_t;

  // series divisor n*(n+1) for n = j+1
  function automatic logic [7:0] ser_div(input logic [3:0] j);
    logic [7:0] d;
    case (j)
      4'd0:    d = 8'd2;
      4'd1:    d = 8'd6;
      4'd2:    d = 8'd12;
      4'd3:    d = 8'd20;
      4'd4:    d = 8'd30;
      4'd5:    d = 8'd42;
      4'd6:    d = 8'd56;
      4'd7:    d = 8'd72;
      4'd8:    d = 8'd90;
      4'd9:    d = 8'd110;
      4'd10:   d = 8'd132;
      4'd11:   d = 8'd156;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^31 / divisor), low estimate of the quotient
  function automatic logic [30:0] ser_recip(input logic [3:0] j);
    logic [30:0] m;
    case (j)
      4'd0:    m = 31'd1073741824;
      4'd1:    m = 31'd357913941;
      4'd2:    m = 31'd178956970;
      4'd3:    m = 31'd107374182;
      4'd4:    m = 31'd71582788;
      4'd5:    m = 31'd51130563;
      4'd6:    m = 31'd38347922;
      4'd7:    m = 31'd29826161;
      4'd8:    m = 31'd23860929;
      4'd9:    m = 31'd19522578;
      4'd10:   m = 31'd16268815;
      4'd11:   m = 31'd13765920;
      default: m = 31'd1073741824;
    endcase
    return m;
  endfunction

  // one xorshift64 step
  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

### src/gaussian_noise_generator_top.sv
// Box-Muller gaussian noise generator: from input transfer to the earliest output transfer a
// sample passes the normalize loop, 24 log squarings, 20 root steps and the trig series.
// One item at a time: the next request is taken once the result is in the output register.
// Synchronous active-low reset loads generator state 0x00C0FFEE12345678;
// a seed write loads the generator state at once.
`timescale 1ns / 1ps
module gaussian_noise_generator_top #(
  parameter int SAMPLE_FRAC_BITS = gng_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gng_pkg::SEED_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gng_pkg::SIGMA_W-1:0]         in_sigma,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gng_pkg::SAMPLE_W-1:0] out_sample
);
  import gng_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic
  gng_dp #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_sigma   (in_sigma),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### src/gng_ctrl.sv
// sequencer for the noise generator datapath
`timescale 1ns / 1ps
module gng_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gng_pkg::sts_t sts,
  output gng_pkg::cmd_t cmd
);
  import gng_pkg::*;

  logic [4:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_stall    = (state_r != OP_IDLE);
  assign cmd.op      = state_r;
  assign cmd.term    = cnt_r[2:0];
  assign cmd.capture = (state_r == OP_IDLE) && in_valid;

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      OP_IDLE:  if (in_valid) state_nxt = OP_ADV1;
      OP_ADV1:  state_nxt = OP_ADV2;
      OP_ADV2:  state_nxt = OP_NORM;
      OP_NORM:  if (sts.norm_done) begin
        state_nxt = OP_LOG;
        cnt_nxt   = '0;
      end
      OP_LOG: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LOG_STEPS - 1)) state_nxt = OP_LQ;
      end
      OP_LQ:    state_nxt = OP_LN;
      OP_LN: begin
        state_nxt = OP_SQRT;
        cnt_nxt   = '0;
      end
      OP_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = OP_ANGLE;
      end
      OP_ANGLE: state_nxt = OP_X2;
      OP_X2: begin
        state_nxt = OP_TMUL;
        cnt_nxt   = '0;
      end
      OP_TMUL:  state_nxt = OP_TDIV;
      OP_TDIV:  state_nxt = OP_TACC;
      OP_TACC: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(TERMS - 1)) state_nxt = OP_PMUL0;
        else state_nxt = OP_TMUL;
      end
      OP_PMUL0: state_nxt = OP_PMUL1;
      OP_PMUL1: state_nxt = OP_PMUL2;
      OP_PMUL2: state_nxt = OP_ROUND;
      OP_ROUND: if (!sts.out_busy) state_nxt = OP_IDLE;
      default:  state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### src/gng_dp.sv
// datapath: generator state, log, root, trig series and output scaling
`timescale 1ns / 1ps
module gng_dp #(
  parameter int SAMPLE_FRAC_BITS = gng_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gng_pkg::SEED_W-1:0]        cfg_data,
  input  logic [gng_pkg::SIGMA_W-1:0]       in_sigma,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gng_pkg::SAMPLE_W-1:0] out_sample,
  input  gng_pkg::cmd_t                     cmd,
  output gng_pkg::sts_t                     sts
);
  import gng_pkg::*;

  localparam int SHIFT = 56 - SAMPLE_FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (SHIFT - 1);
  localparam logic [63:0] POS_LIM = (64'(1) << (SAMPLE_W - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'(1) << (SAMPLE_W - 1);

  logic [63:0]         gen_r;
  logic [SIGMA_W-1:0]  sigma_r;
  logic [52:0]         kk_r;
  logic [5:0]          lz_r;
  logic [30:0]         m_r;
  logic [23:0]         frac_r;
  logic [29:0]         lq_r;
  logic [39:0]         v_r, res_r, bit_r;
  logic [31:0]         phase_r;
  logic                odd_r, neg_r;
  logic [29:0]         x_r, x2_r, q_r;
  logic [30:0]         term_r;
  logic [31:0]         sum_r;
  logic [37:0]         sr_r;
  logic [63:0]         acc_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;

  logic [63:0] adv;
  logic [52:0] k_raw;
  logic [61:0] sq, ln_prod;
  logic [31:0] sq_t;
  logic [39:0] rt_sum;
  logic [2:0]  oct;
  logic [29:0] a_ang;
  logic [60:0] ang_prod, tm_prod, td_prod;
  logic [59:0] x2_prod;
  logic [3:0]  tj;
  logic [7:0]  dv;
  logic [37:0] qd;
  logic [30:0] rem;
  logic [29:0] qf;
  logic [24:0] trig;
  logic [63:0] rnd, mag;
  logic [SAMPLE_W-1:0] sat;

  assign sts.norm_done = kk_r[52];
  assign sts.out_busy  = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_sample    = $signed(out_sample_r);

  // combinational pieces for each operation
  always_comb begin
    adv      = xs_step(gen_r);
    k_raw    = adv[63:11];
    sq       = 62'(m_r) * 62'(m_r);
    sq_t     = sq[61:30];
    ln_prod  = 62'(lq_r) * 62'(LN2_Q32);
    rt_sum   = res_r + bit_r;
    oct      = phase_r[31:29];
    a_ang    = oct[0] ? (30'h20000000 - {1'b0, phase_r[28:0]}) : {1'b0, phase_r[28:0]};
    ang_prod = 61'(a_ang) * 61'(HALF_PI_Q30);
    x2_prod  = 60'(x_r) * 60'(x_r);
    tm_prod  = 61'(term_r) * 61'(x2_r);
    tj       = 4'({cmd.term, 1'b0}) + 4'(odd_r);
    dv       = ser_div(tj);
    td_prod  = 61'(term_r) * 61'(ser_recip(tj));
    qd       = 38'(q_r) * 38'(dv);
    rem      = term_r - qd[30:0];
    qf       = q_r + 30'(rem >= 31'(dv));
    trig     = sum_r[30:6];
    rnd      = acc_r + HALF;
    mag      = rnd >> SHIFT;
    if (neg_r) sat = (mag > NEG_LIM) ? SAMPLE_W'(0) - NEG_LIM[SAMPLE_W-1:0]
                                     : SAMPLE_W'(0) - mag[SAMPLE_W-1:0];
    else       sat = (mag > POS_LIM) ? POS_LIM[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
  end

  // generator state and output register, reset or reseeded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_ROUND && !sts.out_busy) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_we) gen_r <= cfg_data;
      else if (cmd.op == OP_ADV1 || cmd.op == OP_ADV2) gen_r <= adv;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) sigma_r <= in_sigma;
    case (cmd.op)
      OP_ADV1: begin
        kk_r <= (k_raw < U1_FLOOR) ? U1_FLOOR : k_raw;
        lz_r <= '0;
      end
      OP_ADV2:  phase_r <= adv[63:32];
      OP_NORM: begin
        // shift the leading one up to the top, four bits at a time where possible
        if (kk_r[52]) begin
          m_r    <= kk_r[52:22];
          frac_r <= '0;
        end else if (kk_r[52:49] == 4'd0) begin
          kk_r <= kk_r << 4;
          lz_r <= lz_r + 6'd4;
        end else begin
          kk_r <= kk_r << 1;
          lz_r <= lz_r + 6'd1;
        end
      end
      OP_LOG: begin
        // one squaring per cycle, one fraction bit out
        if (sq_t[31]) begin
          m_r    <= sq_t[31:1];
          frac_r <= {frac_r[22:0], 1'b1};
        end else begin
          m_r    <= sq_t[30:0];
          frac_r <= {frac_r[22:0], 1'b0};
        end
      end
      OP_LQ:    lq_r <= {6'(lz_r + 6'd1), 24'd0} - {6'd0, frac_r};
      OP_LN: begin
        v_r   <= {1'b0, ln_prod[61:31], 8'd0};
        res_r <= '0;
        bit_r <= 40'(1) << 38;
      end
      OP_SQRT: begin
        // bitwise integer square root
        if (v_r >= rt_sum) begin
          v_r   <= v_r - rt_sum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_ANGLE: begin
        x_r   <= ang_prod[59:30];
        odd_r <= oct[0] ^ oct[1];
        neg_r <= 3'(oct + 3'd2) >= 3'd4;
      end
      OP_X2: begin
        x2_r   <= x2_prod[59:30];
        term_r <= odd_r ? {1'b0, x_r} : ONE_Q30;
        sum_r  <= odd_r ? {2'b0, x_r} : {1'b0, ONE_Q30};
      end
      OP_TMUL:  term_r <= tm_prod[60:30];
      OP_TDIV:  q_r <= td_prod[60:31];
      OP_TACC: begin
        term_r <= {1'b0, qf};
        if (!cmd.term[0]) sum_r <= sum_r - {2'b0, qf};
        else              sum_r <= sum_r + {2'b0, qf};
      end
      OP_PMUL0: sr_r <= 38'(sigma_r) * 38'(res_r[19:0]);
      OP_PMUL1: acc_r <= 64'(sr_r[18:0]) * 64'(trig);
      OP_PMUL2: acc_r <= acc_r + ((64'(sr_r[37:19]) * 64'(trig)) << 19);
      OP_ROUND: if (!sts.out_busy) out_sample_r <= sat;
      default: ;
    endcase
  end

endmodule

### tb/tb_gaussian_noise_generator_top.sv
// testbench for the gaussian noise generator: directed and random sigma transfers checked
// against a bit-exact fixed-point Box-Muller predictor
`timescale 1ns / 1ps
module tb_gaussian_noise_generator_top;
  import gng_pkg::*;

  localparam int FRAC = SAMPLE_FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SEED_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SIGMA_W-1:0] in_sigma = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;

  // predictor state and expected samples
  logic [63:0] noise_state;
  logic [SAMPLE_W-1:0] pending_samples[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gaussian_noise_generator_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_sigma(in_sigma),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample)
  );

  // one xorshift step of the predictor state
  function automatic logic [63:0] step_noise();
    logic [63:0] x;
    x = noise_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    noise_state = x;
    return x;
  endfunction

  // -log2(k / 2^53) in Q.24 by normalize and repeated squaring
  function automatic logic [63:0] neg_log2(logic [63:0] k);
    int p;
    logic [63:0] m, frac;
    p = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) if (k[i]) p = i;
    m = (p >= 30) ? (k >> (p - 30)) : (k << (30 - p));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(53 - p) << 24) - frac;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // cosine or sine series in Q.30 on [0, pi/4]
  function automatic logic [63:0] series(logic [63:0] x, bit odd);
    logic [63:0] term, sum, x2, n;
    term = odd ? x : 64'd1 << 30;
    sum = term;
    x2 = (x * x) >> 30;
    n = odd ? 64'd2 : 64'd1;
    for (int i = 0; i < 6; i++) begin
      term = (term * x2) >> 30;
      term = term / (n * (n + 1));
      n = n + 2;
      if (i % 2 == 0) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // expected sample for one sigma, advancing the predictor state
  function automatic logic [SAMPLE_W-1:0] gauss_sample(logic [SIGMA_W-1:0] sigma);
    logic [63:0] k, phase, lq, r, radius, a, x, trig, prod, mag, lim;
    logic [2:0] oct;
    bit neg;
    k = step_noise() >> 11;
    phase = step_noise() >> 32;
    if (k < 64'd9008) k = 64'd9008;
    lq = neg_log2(k);
    r = (lq * 64'hB17217F8) >> 31;
    radius = int_root(r << 8);
    oct = phase[31:29];
    a = {35'd0, phase[28:0]};
    if (oct[0]) a = (64'd1 << 29) - a;
    x = (a * 64'h6487ED51) >> 30;
    trig = series(x, ((oct + 3'd1) & 3'd2) != 0);
    neg = ((oct + 3'd2) & 3'd4) != 0;
    prod = (64'(sigma) * radius) * (trig >> 6);
    mag = (prod + (64'd1 << (55 - FRAC))) >> (56 - FRAC);
    lim = 64'd1 << (SAMPLE_W - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return SAMPLE_W'((64'd1 << SAMPLE_W) - mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return SAMPLE_W'(mag);
  endfunction

  function automatic int gap_len();
    if (no_gaps) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  // send one sigma, predict at its transfer, then an optional gap
  task automatic send_sigma(logic [SIGMA_W-1:0] sigma);
    int gap;
    in_valid <= 1'b1;
    in_sigma <= sigma;
    do @(posedge clk); while (in_stall);
    pending_samples.push_back(gauss_sample(sigma));
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every expected sample has arrived and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    noise_state = value;
  endtask

  function automatic logic [SIGMA_W-1:0] rand_sigma();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SIGMA_W'($urandom_range(0, 255));
      default: return SIGMA_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
    mismatches++;
    $display("sample mismatch at %0t: expected %0d got %0d", $realtime,
             $signed(want), $signed(got));
  endtask

  // output check on each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        $display("unexpected sample %0d at %0t", out_sample, $realtime);
      end else begin
        logic [SAMPLE_W-1:0] want;
        want = pending_samples.pop_front();
        if (want !== out_sample) report_mismatch(want, out_sample);
      end
    end
  end

  // output stall driver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (no_gaps || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 60);
        out_stall <= 1'b1;
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT + DRAIN_CYCLES + HOLD_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // reset seed with extreme and alternating sigma values
  task automatic test_reset_seed();
    logic [SIGMA_W-1:0] vals[8] = '{18'd0, 18'd1, 18'h3FFFF, 18'h10000, 18'h2AAAA,
                                    18'h15555, 18'h20000, 18'h0FFFF};
    foreach (vals[i]) send_sigma(vals[i]);
    drain();
  endtask

  // zero seed: generator stuck, u1 floor and zero phase, largest radius
  task automatic test_zero_seed();
    write_seed(64'd0);
    send_sigma('1);
    send_sigma(18'd0);
    send_sigma(18'h10000);
    send_sigma(18'h3FFFE);
    drain();
  endtask

  // seed extremes
  task automatic test_seed_extremes();
    write_seed(64'd1);
    repeat (4) send_sigma(rand_sigma());
    drain();
    write_seed('1);
    repeat (4) send_sigma(rand_sigma());
    drain();
    write_seed(64'h8000_0000_0000_0000);
    repeat (3) send_sigma('1);
    drain();
  endtask

  // random sigma under several random seeds
  task automatic test_random_samples();
    for (int phase_n = 0; phase_n < 10; phase_n++) begin
      write_seed({$urandom(), $urandom()} | 64'd1);
      no_gaps = (phase_n % 4 == 3);
      repeat (120) send_sigma(rand_sigma());
      drain();
      no_gaps = 1'b0;
    end
  endtask

  // long output hold-off while requests keep coming
  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (30) send_sigma(rand_sigma());
    drain();
  endtask

  initial begin
    noise_state = SEED_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_seed();
    test_zero_seed();
    test_seed_extremes();
    test_random_samples();
    test_output_hold();
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
